### src/xfd_pkg.sv
// ----------------------------------------------------------------------------
// xfd_pkg
// Shared types and constants for the framed byte stream deframer.
// ----------------------------------------------------------------------------
package xfd_pkg;

    // Frame marker bytes
    localparam logic [7:0] HDR_FIRST  = 8'h55;
    localparam logic [7:0] HDR_SECOND = 8'hAA;
    localparam logic [7:0] TAIL_BYTE  = 8'hF0;

    // Result kinds
    localparam logic [2:0] KIND_DATA      = 3'd0;
    localparam logic [2:0] KIND_EMPTY     = 3'd1;
    localparam logic [2:0] KIND_CHECK_ERR = 3'd2;
    localparam logic [2:0] KIND_TIMEOUT   = 3'd3;
    localparam logic [2:0] KIND_BAD_HDR   = 3'd4;

    // Configuration register indexes
    localparam int         CFG_IDX_W   = 1;
    localparam logic [0:0] REG_ADDRESS = 1'd0;
    localparam logic [0:0] REG_TIMEOUT = 1'd1;
    localparam int         CFG_DATA_W  = 16;

    // Byte counter / frame length width
    localparam int CNT_W = 6;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] payload_byte;
        logic       last;
    } t_out_item;

    // Parser to output stage: one direct result or a release request
    typedef struct packed {
        logic             res_valid;
        t_out_item        res;
        logic             rel_start;
        logic [CNT_W-1:0] rel_len;
    } t_parse_evt;

endpackage

### src/xfd_ram.sv
// ----------------------------------------------------------------------------
// xfd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module xfd_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### src/xfd_parser.sv
// ----------------------------------------------------------------------------
// xfd_parser
// Header hunt, address/length checks, payload capture, checksum, timeout.
// ----------------------------------------------------------------------------
module xfd_parser #(
    parameter int MAX_PAYLOAD = 32,
    parameter int TIMER_WIDTH = 16,
    parameter int ADDR_W      = 5
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  xfd_pkg::t_in_item            i_item,
    input  logic [7:0]                   i_module_address,
    input  logic [xfd_pkg::CFG_DATA_W-1:0] i_timeout_ticks,
    output xfd_pkg::t_parse_evt          o_evt,
    output logic                         o_wr_en,
    output logic [ADDR_W-1:0]            o_wr_addr,
    output logic [7:0]                   o_wr_data
);
    import xfd_pkg::*;

    localparam int CMP_W = (TIMER_WIDTH > CFG_DATA_W) ? TIMER_WIDTH : CFG_DATA_W;

    typedef enum logic [2:0] {
        PH_HUNT1,
        PH_HUNT2,
        PH_ADDR,
        PH_LEN,
        PH_DATA,
        PH_CHECK,
        PH_TAIL
    } t_phase;

    t_phase                 r_phase, n_phase;
    logic [CNT_W-1:0]       r_len, n_len;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [7:0]             r_xor, n_xor;
    logic [TIMER_WIDTH-1:0] r_tick, n_tick;

    logic       in_frame;
    logic [7:0] b;
    logic [CNT_W-1:0] cnt_inc;

    assign b        = i_item.rx_byte;
    assign cnt_inc  = r_cnt + CNT_W'(1);
    assign in_frame = (r_phase == PH_DATA) || (r_phase == PH_CHECK) || (r_phase == PH_TAIL);

    always_comb begin
        n_phase   = r_phase;
        n_len     = r_len;
        n_cnt     = r_cnt;
        n_xor     = r_xor;
        n_tick    = r_tick;
        o_evt     = '0;
        o_wr_en   = 1'b0;
        o_wr_addr = r_cnt[ADDR_W-1:0];
        o_wr_data = b;

        if (i_accept) begin
            if (i_item.mode) begin
                // timer tick: only counts while a frame body is awaited
                if (in_frame) begin
                    if (r_tick != '1) begin
                        n_tick = r_tick + TIMER_WIDTH'(1);
                    end
                    if (CMP_W'(n_tick) > CMP_W'(i_timeout_ticks)) begin
                        n_phase            = PH_HUNT1;
                        o_evt.res_valid    = 1'b1;
                        o_evt.res.kind     = KIND_TIMEOUT;
                        o_evt.res.last     = 1'b1;
                    end
                end
            end else begin
                unique case (r_phase)
                    PH_HUNT1: begin
                        if (b == HDR_FIRST) begin
                            n_phase = PH_HUNT2;
                        end
                    end
                    PH_HUNT2: begin
                        if (b == HDR_SECOND) begin
                            n_phase = PH_ADDR;
                        end else if (b != HDR_FIRST) begin
                            n_phase = PH_HUNT1;
                        end
                    end
                    PH_ADDR: begin
                        if (b != i_module_address) begin
                            n_phase         = PH_HUNT1;
                            o_evt.res_valid = 1'b1;
                            o_evt.res.kind  = KIND_BAD_HDR;
                            o_evt.res.last  = 1'b1;
                        end else begin
                            n_xor   = b;
                            n_phase = PH_LEN;
                        end
                    end
                    PH_LEN: begin
                        if (b > 8'(MAX_PAYLOAD)) begin
                            n_phase         = PH_HUNT1;
                            o_evt.res_valid = 1'b1;
                            o_evt.res.kind  = KIND_BAD_HDR;
                            o_evt.res.last  = 1'b1;
                        end else begin
                            n_xor   = r_xor ^ b;
                            n_len   = b[CNT_W-1:0];
                            n_cnt   = '0;
                            n_tick  = '0;
                            n_phase = (b == 8'h00) ? PH_CHECK : PH_DATA;
                        end
                    end
                    PH_DATA: begin
                        o_wr_en = 1'b1;
                        n_xor   = r_xor ^ b;
                        n_cnt   = cnt_inc;
                        if (cnt_inc >= r_len) begin
                            n_phase = PH_CHECK;
                        end
                    end
                    PH_CHECK: begin
                        n_xor   = r_xor ^ b;
                        n_phase = PH_TAIL;
                    end
                    PH_TAIL: begin
                        n_phase = PH_HUNT1;
                        if (r_xor != 8'h00 || b != TAIL_BYTE) begin
                            o_evt.res_valid = 1'b1;
                            o_evt.res.kind  = KIND_CHECK_ERR;
                            o_evt.res.last  = 1'b1;
                        end else if (r_len == '0) begin
                            o_evt.res_valid = 1'b1;
                            o_evt.res.kind  = KIND_EMPTY;
                            o_evt.res.last  = 1'b1;
                        end else begin
                            o_evt.rel_start = 1'b1;
                            o_evt.rel_len   = r_len;
                        end
                    end
                    default: begin
                        n_phase = PH_HUNT1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT1;
            r_len   <= '0;
            r_cnt   <= '0;
            r_xor   <= '0;
            r_tick  <= '0;
        end else begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_cnt   <= n_cnt;
            r_xor   <= n_xor;
            r_tick  <= n_tick;
        end
    end

endmodule

### src/xfd_release.sv
// ----------------------------------------------------------------------------
// xfd_release
// Output register plus payload release sequencer reading the payload RAM.
// ----------------------------------------------------------------------------
module xfd_release #(
    parameter int ADDR_W = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  xfd_pkg::t_parse_evt i_evt,
    input  logic [7:0]          i_rd_data,
    input  logic                i_out_stall,
    output logic                o_rd_en,
    output logic [ADDR_W-1:0]   o_rd_addr,
    output logic                o_busy,
    output logic                o_out_free,
    output logic                o_out_valid,
    output xfd_pkg::t_out_item  o_out_item
);
    import xfd_pkg::*;

    typedef enum logic [1:0] {
        REL_IDLE,
        REL_RD,
        REL_WR
    } t_rel_state;

    t_rel_state       r_state;
    logic [CNT_W-1:0] r_idx;
    logic [CNT_W-1:0] r_len;
    logic             r_out_valid;
    t_out_item        r_out_item;

    logic [CNT_W-1:0] idx_inc;
    logic             is_last;
    logic             load_res;
    logic             load_data;

    assign idx_inc    = r_idx + CNT_W'(1);
    assign is_last    = (idx_inc == r_len);
    assign o_out_free = !r_out_valid || !i_out_stall;
    assign o_busy     = (r_state != REL_IDLE);
    assign o_rd_en    = (r_state == REL_RD);
    assign o_rd_addr  = r_idx[ADDR_W-1:0];
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // output register loads: a direct result, or a payload byte from the RAM
    assign load_res  = (r_state == REL_IDLE) && i_evt.res_valid;
    assign load_data = (r_state == REL_WR) && o_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= REL_IDLE;
            r_idx       <= '0;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load_res || load_data) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                REL_IDLE: begin
                    if (i_evt.res_valid) begin
                        r_out_item <= i_evt.res;
                    end
                    if (i_evt.rel_start) begin
                        r_idx   <= '0;
                        r_len   <= i_evt.rel_len;
                        r_state <= REL_RD;
                    end
                end
                REL_RD: begin
                    r_state <= REL_WR;
                end
                REL_WR: begin
                    // read data held in the RAM output until the slot frees
                    if (load_data) begin
                        r_out_item.kind         <= KIND_DATA;
                        r_out_item.payload_byte <= i_rd_data;
                        r_out_item.last         <= is_last;
                        r_idx                   <= idx_inc;
                        r_state                 <= is_last ? REL_IDLE : REL_RD;
                    end
                end
                default: begin
                    r_state <= REL_IDLE;
                end
            endcase
        end
    end

endmodule

### src/xor_frame_deframer.sv
// ----------------------------------------------------------------------------
// xor_frame_deframer
// Receive-side parser for 0x55 0xAA addr len payload xor 0xF0 frames,
// with buffered payload release and a tick-driven frame timeout.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake                 payload
//  -------  ---  ------------------------  ------------------------------
//  in       in   i_in_valid / o_in_stall   i_in_item  (mode, rx_byte)
//  out      out  o_out_valid / i_out_stall o_out_item (kind, byte, last)
//  cfg      in   i_cfg_we                  i_cfg_idx, i_cfg_data
//
//  Each input item passes through the parser combinationally; its single result
//  (error, empty frame) lands in the output register the next cycle.
//  A good frame with N payload bytes releases them byte by byte: for each,
//  a payload RAM read, then an output register load once the slot is free.
//  No input item is taken during the release burst, nor while the output
//  register is full and stalled.
//  Reset is synchronous, active low; config returns to address 1 and a
//  timeout of 300 ticks. The payload RAM needs no clearing: only entries
//  written in the current frame are ever read.
//
module xor_frame_deframer #(
    parameter int MAX_PAYLOAD = 32,
    parameter int TIMER_WIDTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  xfd_pkg::t_in_item               i_in_item,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output xfd_pkg::t_out_item              o_out_item,
    input  logic                            i_cfg_we,
    input  logic [xfd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [xfd_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import xfd_pkg::*;

    localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    // configuration registers
    logic [7:0]            r_module_address;
    logic [CFG_DATA_W-1:0] r_timeout_ticks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_module_address <= 8'd1;
            r_timeout_ticks  <= CFG_DATA_W'(300);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ADDRESS: r_module_address <= i_cfg_data[7:0];
                REG_TIMEOUT: r_timeout_ticks  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    t_parse_evt        evt;
    logic              in_accept;
    logic              busy;
    logic              out_free;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;

    // hold off input during a release burst or while the result slot is blocked
    assign o_in_stall = busy || !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    xfd_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .TIMER_WIDTH (TIMER_WIDTH),
        .ADDR_W      (ADDR_W)
    ) u_parser (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (in_accept),
        .i_item           (i_in_item),
        .i_module_address (r_module_address),
        .i_timeout_ticks  (r_timeout_ticks),
        .o_evt            (evt),
        .o_wr_en          (wr_en),
        .o_wr_addr        (wr_addr),
        .o_wr_data        (wr_data)
    );

    // payload store; writes (frame body) and reads (release) never overlap
    xfd_ram #(
        .WIDTH  (8),
        .DEPTH  (MAX_PAYLOAD),
        .ADDR_W (ADDR_W)
    ) u_payload_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    xfd_release #(
        .ADDR_W (ADDR_W)
    ) u_release (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_evt       (evt),
        .i_rd_data   (rd_data),
        .i_out_stall (i_out_stall),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .o_busy      (busy),
        .o_out_free  (out_free),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

`ifndef ASSERT_OFF
    // no RAM write may coincide with a release read
    a_no_wr_during_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(wr_en && busy))
        else $error("payload write during release");

    // a release request always starts the sequencer
    a_release_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        evt.rel_start |=> busy)
        else $error("release did not start");

    // non-data results carry a zero byte
    a_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.kind != KIND_DATA) |-> (o_out_item.payload_byte == 8'h00))
        else $error("nonzero byte on non-data result");
`endif

endmodule
